// ===== hdl/mbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsp_pkg: shared types and constants of the box stream parser
// Result kinds, the event record passed from the front end to the back end,
// queue status, and the fixed values of the box header format.
// ----------------------------------------------------------------------------
package mbsp_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_MAJOR   = 3'd1,
    KIND_MINOR   = 3'd2,
    KIND_COMPAT  = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_BOX_END = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_t;

  // One record per input byte that causes results. When with_end is set a
  // box-end result follows the first one, with the same box fields.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] box_offset;
    logic [63:0] box_length;
    logic [31:0] box_type;
    logic [31:0] value;
    logic [7:0]  byte_index;
    logic        with_end;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int          QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [7:0]  DUMP_LIMIT_RESET    = 8'd16;
  localparam logic [31:0] FTYP_TYPE           = 32'h6674_7970;
  localparam logic [63:0] LEN_TO_END          = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIZE_EXTENDED       = 64'd1;
  localparam logic [63:0] SHORT_HDR           = 64'd8;
  localparam logic [63:0] LONG_HDR            = 64'd16;
  localparam logic [7:0]  DUMP_COUNT_MAX      = 8'd255;

endpackage

// ===== hdl/mbsp_front.sv =====
// ----------------------------------------------------------------------------
// mbsp_front: header parsing and payload classification
// Consumes one byte per accepted transaction, tracks the box header and
// payload position, and produces at most one event record per byte.
// ----------------------------------------------------------------------------
module mbsp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [7:0]    cfg_data,
  input  logic          byte_take,
  input  logic [7:0]    data_byte,
  output logic          rec_valid,
  output mbsp_pkg::rec_t rec
);
  import mbsp_pkg::*;

  localparam logic [4:0] PH_SIZE_LAST = 5'd3;
  localparam logic [4:0] PH_TYPE      = 5'd4;
  localparam logic [4:0] PH_TYPE_LAST = 5'd7;
  localparam logic [4:0] PH_EXT       = 5'd8;
  localparam logic [4:0] PH_EXT_LAST  = 5'd15;
  localparam logic [4:0] PH_BODY      = 5'd16;

  localparam logic [3:0] FP_MAJOR  = 4'd4;
  localparam logic [3:0] FP_MINOR  = 4'd8;
  localparam logic [3:0] FP_COMPAT = 4'd12;

  logic [7:0]  dump_limit;
  logic [4:0]  header_phase, header_phase_next;
  logic        error_latched, error_latched_next;
  logic [63:0] length_acc, length_acc_next;
  logic [31:0] type_acc, type_acc_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [63:0] start_offset, start_offset_next;
  logic [3:0]  field_phase, field_phase_next;
  logic [31:0] field_acc, field_acc_next;
  logic [7:0]  dump_count, dump_count_next;

  logic [63:0] len_shift;
  logic [31:0] type_shift;
  logic        open_en;
  logic [63:0] open_len;
  logic [63:0] open_hdr;
  logic [31:0] fa_new;
  logic [3:0]  fp_inc;
  logic        body_res;

  assign len_shift  = {length_acc[55:0], data_byte};
  assign type_shift = {type_acc[23:0], data_byte};
  assign fa_new     = {((field_phase[1:0] == 2'd0) ? 24'd0 : field_acc[23:0]), data_byte};
  assign fp_inc     = field_phase + 4'd1;

  always_comb begin
    header_phase_next  = header_phase;
    error_latched_next = error_latched;
    length_acc_next    = length_acc;
    type_acc_next      = type_acc;
    bytes_left_next    = bytes_left;
    start_offset_next  = start_offset;
    field_phase_next   = field_phase;
    field_acc_next     = field_acc;
    dump_count_next    = dump_count;
    open_en            = 1'b0;
    open_len           = length_acc;
    open_hdr           = SHORT_HDR;
    body_res           = 1'b0;
    rec_valid          = 1'b0;
    rec.kind           = KIND_HEADER;
    rec.box_offset     = start_offset;
    rec.box_length     = length_acc;
    rec.box_type       = type_acc;
    rec.value          = 32'd0;
    rec.byte_index     = 8'd0;
    rec.with_end       = 1'b0;

    if (byte_take && !error_latched) begin
      if (header_phase < PH_TYPE) begin
        length_acc_next   = len_shift;
        header_phase_next = header_phase + 5'd1;
        if (header_phase == PH_SIZE_LAST && len_shift == 64'd0) begin
          length_acc_next = LEN_TO_END;
        end
      end else if (header_phase < PH_EXT) begin
        type_acc_next     = type_shift;
        header_phase_next = header_phase + 5'd1;
        if (header_phase == PH_TYPE_LAST) begin
          if (length_acc == SIZE_EXTENDED) begin
            length_acc_next   = 64'd0;
            header_phase_next = PH_EXT;
          end else if (length_acc < SHORT_HDR) begin
            error_latched_next = 1'b1;
            rec_valid          = 1'b1;
            rec.kind           = KIND_ERROR;
            rec.box_type       = type_shift;
          end else begin
            open_en  = 1'b1;
            open_len = length_acc;
            open_hdr = SHORT_HDR;
          end
        end
      end else if (header_phase < PH_BODY) begin
        length_acc_next   = len_shift;
        header_phase_next = header_phase + 5'd1;
        if (header_phase == PH_EXT_LAST) begin
          if (len_shift < LONG_HDR) begin
            error_latched_next = 1'b1;
            rec_valid          = 1'b1;
            rec.kind           = KIND_ERROR;
            rec.box_length     = len_shift;
          end else begin
            open_en  = 1'b1;
            open_len = len_shift;
            open_hdr = LONG_HDR;
          end
        end
      end else begin
        bytes_left_next = bytes_left - 64'd1;
        if (type_acc == FTYP_TYPE) begin
          field_acc_next   = fa_new;
          field_phase_next = fp_inc;
          if (fp_inc == FP_MAJOR) begin
            body_res  = 1'b1;
            rec.kind  = KIND_MAJOR;
            rec.value = fa_new;
          end else if (fp_inc == FP_MINOR) begin
            body_res  = 1'b1;
            rec.kind  = KIND_MINOR;
            rec.value = fa_new;
          end else if (fp_inc >= FP_COMPAT) begin
            body_res         = 1'b1;
            rec.kind         = KIND_COMPAT;
            rec.value        = fa_new;
            field_phase_next = FP_MINOR;
          end
        end else begin
          if (dump_count < dump_limit) begin
            body_res       = 1'b1;
            rec.kind       = KIND_PAYLOAD;
            rec.value      = {24'd0, data_byte};
            rec.byte_index = dump_count;
          end
          if (dump_count != DUMP_COUNT_MAX) begin
            dump_count_next = dump_count + 8'd1;
          end
        end
        rec_valid = body_res;
        if (bytes_left == 64'd1) begin
          rec_valid = 1'b1;
          if (body_res) begin
            rec.with_end = 1'b1;
          end else begin
            rec.kind = KIND_BOX_END;
          end
          start_offset_next = start_offset + length_acc;
          length_acc_next   = 64'd0;
          type_acc_next     = 32'd0;
          header_phase_next = 5'd0;
        end
      end

      if (open_en) begin
        bytes_left_next   = open_len - open_hdr;
        header_phase_next = PH_BODY;
        field_phase_next  = 4'd0;
        field_acc_next    = 32'd0;
        dump_count_next   = 8'd0;
        rec_valid         = 1'b1;
        rec.kind          = KIND_HEADER;
        rec.box_length    = open_len;
        rec.box_type      = type_acc_next;
        // A header that leaves no payload closes the box on the same byte.
        if (open_len == open_hdr) begin
          rec.with_end      = 1'b1;
          start_offset_next = start_offset + open_len;
          length_acc_next   = 64'd0;
          type_acc_next     = 32'd0;
          header_phase_next = 5'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dump_limit    <= DUMP_LIMIT_RESET;
      header_phase  <= 5'd0;
      error_latched <= 1'b0;
      length_acc    <= 64'd0;
      type_acc      <= 32'd0;
      bytes_left    <= 64'd0;
      start_offset  <= 64'd0;
      field_phase   <= 4'd0;
      field_acc     <= 32'd0;
      dump_count    <= 8'd0;
    end else begin
      if (cfg_write) begin
        dump_limit <= cfg_data;
      end
      header_phase  <= header_phase_next;
      error_latched <= error_latched_next;
      length_acc    <= length_acc_next;
      type_acc      <= type_acc_next;
      bytes_left    <= bytes_left_next;
      start_offset  <= start_offset_next;
      field_phase   <= field_phase_next;
      field_acc     <= field_acc_next;
      dump_count    <= dump_count_next;
    end
  end

endmodule

// ===== hdl/mbsp_queue.sv =====
// ----------------------------------------------------------------------------
// mbsp_queue: event record queue
// A short first-in first-out buffer of event records between the front end
// and the back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mbsp_queue #(
  parameter int DEPTH = mbsp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mbsp_pkg::rec_t   push_rec,
  input  logic             pop,
  output mbsp_pkg::rec_t   head_rec,
  output mbsp_pkg::q_stat_t stat
);
  import mbsp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head_rec   = entries[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

// ===== hdl/mbsp_back.sv =====
// ----------------------------------------------------------------------------
// mbsp_back: result output stage
// Expands each event record into one or two results and holds them in the
// output register until the downstream side takes them.
// ----------------------------------------------------------------------------
module mbsp_back (
  input  logic           clk,
  input  logic           rst,
  input  mbsp_pkg::rec_t head_rec,
  input  logic           q_empty,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_ready,
  output mbsp_pkg::kind_t kind,
  output logic [63:0]    box_offset,
  output logic [63:0]    box_length,
  output logic [31:0]    box_type,
  output logic [31:0]    value,
  output logic [7:0]     byte_index,
  output logic           last
);
  import mbsp_pkg::*;

  logic pend_end;
  logic advance;

  // The output register moves when it is empty or its transaction completes.
  assign advance = !result_valid || result_ready;
  assign pop     = advance && !pend_end && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_end     <= 1'b0;
    end else if (advance) begin
      if (pend_end) begin
        result_valid <= 1'b1;
        pend_end     <= 1'b0;
      end else if (!q_empty) begin
        result_valid <= 1'b1;
        pend_end     <= head_rec.with_end;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_end) begin
        kind       <= KIND_BOX_END;
        value      <= 32'd0;
        byte_index <= 8'd0;
        last       <= 1'b1;
      end else if (!q_empty) begin
        kind       <= head_rec.kind;
        box_offset <= head_rec.box_offset;
        box_length <= head_rec.box_length;
        box_type   <= head_rec.box_type;
        value      <= head_rec.value;
        byte_index <= head_rec.byte_index;
        last       <= !head_rec.with_end;
      end
    end
  end

endmodule

// ===== hdl/mp4_box_stream_parser.sv =====
// A byte's first result passes through the record queue and then the output register.
// Throughput: one byte per cycle while the record queue is not full; the output
// register delivers one result per cycle while result_ready is high, so a byte that
// yields a result and also closes a box gives two results, which the record queue absorbs.
// Reset: synchronous rst clears all parser state and the queue, and sets dump_limit
// to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// mp4_box_stream_parser: top-level box splitter for a file byte stream
// Front end parses box headers and classifies payload bytes, a short queue
// holds event records, and the back end presents results one at a time.
// ----------------------------------------------------------------------------
module mp4_box_stream_parser #(
  parameter int QUEUE_DEPTH = mbsp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [63:0] box_offset,
  output logic [63:0] box_length,
  output logic [31:0] box_type,
  output logic [31:0] value,
  output logic [7:0]  byte_index,
  output logic        last
);
  import mbsp_pkg::*;

  logic    byte_take;
  logic    rec_valid;
  rec_t    rec;
  rec_t    head_rec;
  q_stat_t q_stat;
  logic    pop;
  kind_t   back_kind;

  assign cfg_ready  = 1'b1;
  assign data_ready = !q_stat.full;
  assign byte_take  = data_valid && data_ready;
  assign kind       = back_kind;

  mbsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .byte_take (byte_take),
    .data_byte (data_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  mbsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_valid),
    .push_rec (rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  mbsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_rec     (head_rec),
    .q_empty      (q_stat.empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (back_kind),
    .box_offset   (box_offset),
    .box_length   (box_length),
    .box_type     (box_type),
    .value        (value),
    .byte_index   (byte_index),
    .last         (last)
  );

`ifndef ASSERT_OFF
  // The front end never writes a record into a full queue.
  assert property (@(posedge clk) disable iff (rst) rec_valid |-> !q_stat.full)
    else $error("record pushed into full queue");

  // A box end is always the final result of its byte.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_BOX_END) |-> last)
    else $error("box end without last");

  // Only payload bytes carry a nonzero byte index.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != KIND_PAYLOAD) |-> (byte_index == 8'd0))
    else $error("byte index set on non-payload result");

  // With a record waiting and the output register free to move, a result is valid on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && (!result_valid || result_ready)) |=> result_valid)
    else $error("queued record not presented");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the box stream parser
// Builds a file byte stream out of well-formed boxes (short and extended
// headers, empty boxes, ftyp boxes with partial brands, dumped payloads),
// predicts every result from its own parser model, and ends each run with a
// bad size or a box that runs to the end of the stream.
// ----------------------------------------------------------------------------
module tb;
  import mbsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PRESSURE_AT    = 300;
  localparam int PRESSURE_LEN   = 400;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] box_offset;
    logic [63:0] box_length;
    logic [31:0] box_type;
    logic [31:0] value;
    logic [7:0]  byte_index;
    logic        last;
  } box_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  kind;
  logic [63:0] box_offset;
  logic [63:0] box_length;
  logic [31:0] box_type;
  logic [31:0] value;
  logic [7:0]  byte_index;
  logic        last;

  mp4_box_stream_parser uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .box_offset   (box_offset),
    .box_length   (box_length),
    .box_type     (box_type),
    .value        (value),
    .byte_index   (byte_index),
    .last         (last)
  );

  always #6 clk = ~clk;

  // Stream bytes waiting for the driver and events waiting for the block.
  logic [7:0]  stream_bytes[$];
  box_event_t  pending_events[$];

  int  mismatches  = 0;
  int  results_in  = 0;
  int  bytes_in    = 0;
  int  bytes_built = 0;
  int  idle_cycles = 0;
  bit  data_fire   = 1'b0;
  bit  idle_en     = 1'b1;
  int  gap_left    = 0;
  int  stall_left  = 0;
  int  press_left  = 0;
  bit  pressed     = 1'b0;

  // Parser model state.
  logic [7:0]  dump_lim;
  logic [4:0]  hdr_phase;
  logic        err_seen;
  logic [63:0] len_acc;
  logic [31:0] fourcc_acc;
  logic [63:0] remaining;
  logic [63:0] box_start;
  logic [3:0]  brand_phase;
  logic [31:0] brand_acc;
  logic [7:0]  dump_seen;

  task automatic reset_model();
    dump_lim    = DUMP_LIMIT_RESET;
    hdr_phase   = 5'd0;
    err_seen    = 1'b0;
    len_acc     = 64'd0;
    fourcc_acc  = 32'd0;
    remaining   = 64'd0;
    box_start   = 64'd0;
    brand_phase = 4'd0;
    brand_acc   = 32'd0;
    dump_seen   = 8'd0;
  endtask

  task automatic emit(input kind_t k, input logic [31:0] v, input logic [7:0] idx);
    box_event_t ev;
    ev.kind       = k;
    ev.box_offset = box_start;
    ev.box_length = len_acc;
    ev.box_type   = fourcc_acc;
    ev.value      = v;
    ev.byte_index = idx;
    ev.last       = 1'b0;
    pending_events.push_back(ev);
  endtask

  task automatic close_box();
    emit(KIND_BOX_END, 32'd0, 8'd0);
    box_start  = box_start + len_acc;
    len_acc    = 64'd0;
    fourcc_acc = 32'd0;
    hdr_phase  = 5'd0;
  endtask

  task automatic open_box(input logic [63:0] hdr_len);
    remaining   = len_acc - hdr_len;
    hdr_phase   = 5'd16;
    brand_phase = 4'd0;
    brand_acc   = 32'd0;
    dump_seen   = 8'd0;
    emit(KIND_HEADER, 32'd0, 8'd0);
    if (remaining == 64'd0) close_box();
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int         base;
    box_event_t tail;
    base = pending_events.size();
    if (!err_seen) begin
      if (hdr_phase < 5'd4) begin
        len_acc   = {len_acc[55:0], b};
        hdr_phase = hdr_phase + 5'd1;
        if (hdr_phase == 5'd4 && len_acc == 64'd0) len_acc = LEN_TO_END;
      end else if (hdr_phase < 5'd8) begin
        fourcc_acc = {fourcc_acc[23:0], b};
        hdr_phase  = hdr_phase + 5'd1;
        if (hdr_phase == 5'd8) begin
          if (len_acc == SIZE_EXTENDED) begin
            // Extended size follows; the phase counter runs on through 8..15.
            len_acc = 64'd0;
          end else if (len_acc < SHORT_HDR) begin
            err_seen = 1'b1;
            emit(KIND_ERROR, 32'd0, 8'd0);
          end else begin
            open_box(SHORT_HDR);
          end
        end
      end else if (hdr_phase < 5'd16) begin
        len_acc   = {len_acc[55:0], b};
        hdr_phase = hdr_phase + 5'd1;
        if (hdr_phase == 5'd16) begin
          if (len_acc < LONG_HDR) begin
            err_seen = 1'b1;
            emit(KIND_ERROR, 32'd0, 8'd0);
          end else begin
            open_box(LONG_HDR);
          end
        end
      end else begin
        remaining = remaining - 64'd1;
        if (fourcc_acc == FTYP_TYPE) begin
          if (brand_phase[1:0] == 2'd0) brand_acc = 32'd0;
          brand_acc   = {brand_acc[23:0], b};
          brand_phase = brand_phase + 4'd1;
          if (brand_phase == 4'd4) begin
            emit(KIND_MAJOR, brand_acc, 8'd0);
          end else if (brand_phase == 4'd8) begin
            emit(KIND_MINOR, brand_acc, 8'd0);
          end else if (brand_phase >= 4'd12) begin
            emit(KIND_COMPAT, brand_acc, 8'd0);
            brand_phase = 4'd8;
          end
        end else begin
          if (dump_seen < dump_lim) emit(KIND_PAYLOAD, {24'd0, b}, dump_seen);
          if (dump_seen < DUMP_COUNT_MAX) dump_seen = dump_seen + 8'd1;
        end
        if (remaining == 64'd0) close_box();
      end
    end
    if (pending_events.size() > base) begin
      tail      = pending_events.pop_back();
      tail.last = 1'b1;
      pending_events.push_back(tail);
    end
  endtask

  task automatic check_result();
    box_event_t got;
    box_event_t want;
    got.kind       = kind_t'(kind);
    got.box_offset = box_offset;
    got.box_length = box_length;
    got.box_type   = box_type;
    got.value      = value;
    got.byte_index = byte_index;
    got.last       = last;
    results_in++;
    if (pending_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with nothing expected: kind %0d off %h len %h",
                 results_in, kind, box_offset, box_length);
    end else begin
      want = pending_events.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs (expected / actual):", results_in);
          $display("  kind %0d / %0d  last %0d / %0d  index %0d / %0d",
                   want.kind, got.kind, want.last, got.last,
                   want.byte_index, got.byte_index);
          $display("  offset %h / %h  length %h / %h",
                   want.box_offset, got.box_offset, want.box_length, got.box_length);
          $display("  type %h / %h  value %h / %h",
                   want.box_type, got.box_type, want.value, got.value);
        end
      end
    end
  endtask

  // Sampling, prediction, checking and the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      data_fire   <= 1'b0;
      idle_cycles <= 0;
      reset_model();
    end else begin
      data_fire <= data_valid && data_ready;
      if (result_valid && result_ready) check_result();
      if (cfg_valid && cfg_ready) dump_lim = cfg_data;
      if (data_valid && data_ready) begin
        parse_byte(data_byte);
        bytes_in++;
      end
      if ((result_valid && result_ready) || (cfg_valid && cfg_ready) ||
          (data_valid && data_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d events outstanding", pending_events.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Byte driver.
  always @(negedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (data_valid && !data_fire) begin
      // Hold the transaction until it is taken.
    end else if (gap_left > 0) begin
      gap_left   <= gap_left - 1;
      data_valid <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      gap_left   <= $urandom_range(0, 16);
      data_valid <= 1'b0;
    end else if (stream_bytes.size() > 0) begin
      data_byte  <= stream_bytes.pop_front();
      data_valid <= 1'b1;
    end else begin
      data_valid <= 1'b0;
    end
  end

  // Result receiver, with one long hold-off so the block backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (press_left > 0) begin
      press_left   <= press_left - 1;
      result_ready <= 1'b0;
    end else if (!pressed && bytes_in >= PRESSURE_AT) begin
      pressed      <= 1'b1;
      press_left   <= PRESSURE_LEN;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 16);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic push_be(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      stream_bytes.push_back(v[8*i +: 8]);
      bytes_built++;
    end
  endtask

  task automatic add_box(input logic [31:0] fourcc, input int plen, input bit ext);
    if (ext) begin
      push_be(SIZE_EXTENDED, 4);
      push_be({32'd0, fourcc}, 4);
      push_be(64'(plen) + LONG_HDR, 8);
    end else begin
      push_be(64'(plen) + SHORT_HDR, 4);
      push_be({32'd0, fourcc}, 4);
    end
    for (int i = 0; i < plen; i++) push_be(64'($urandom_range(0, 255)), 1);
  endtask

  task automatic add_random_boxes(input int nbytes);
    int          stop_at;
    bit          is_ftyp;
    logic [31:0] fourcc;
    stop_at = bytes_built + nbytes;
    while (bytes_built < stop_at) begin
      is_ftyp = ($urandom_range(0, 3) == 0);
      fourcc  = is_ftyp ? FTYP_TYPE : $urandom;
      add_box(fourcc, is_ftyp ? $urandom_range(0, 30) : $urandom_range(0, 40),
              $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (stream_bytes.size() != 0 || data_valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dump_limit(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ending;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: an empty box with an all-ones type, then an ftyp box whose
    // last compatible brand is cut short by the box end.
    add_box(32'hFFFF_FFFF, 0, 1'b0);
    add_box(FTYP_TYPE, 14, 1'b0);
    wait_idle();

    write_dump_limit(8'd0);
    idle_en = ($urandom_range(0, 3) != 0);
    add_random_boxes(120);
    wait_idle();

    // Largest dump limit with a payload long enough to run the counter to its cap.
    write_dump_limit(8'd255);
    idle_en = 1'b1;
    add_box(32'h6D64_6174, 270, 1'b1);
    add_random_boxes(40);
    wait_idle();

    repeat (2) begin
      write_dump_limit(8'($urandom_range(1, 254)));
      idle_en = ($urandom_range(0, 3) != 0);
      add_random_boxes(100);
      wait_idle();
    end

    // Final part runs without idling and ends in a terminal condition.
    write_dump_limit(8'($urandom_range(0, 40)));
    idle_en = 1'b0;
    add_random_boxes(80);
    ending = $urandom_range(0, 2);
    case (ending)
      0: begin
        push_be(64'($urandom_range(2, 7)), 4);
        push_be(64'($urandom), 4);
      end
      1: begin
        push_be(SIZE_EXTENDED, 4);
        push_be(64'($urandom), 4);
        push_be(64'($urandom_range(0, 15)), 8);
      end
      default: begin
        // Size zero: the box runs to the end of the stream and never closes.
        push_be(64'd0, 4);
        push_be({32'd0, ($urandom_range(0, 1) == 0) ? FTYP_TYPE : $urandom}, 4);
      end
    endcase
    repeat (40) push_be(64'($urandom_range(0, 255)), 1);
    wait_idle();
    repeat (20) @(posedge clk);

    if (pending_events.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
